### hdl/soft_knee_compressor_curve_assert.svh
// assertion macros for the soft-knee compressor curve
`ifndef SOFT_KNEE_COMPRESSOR_CURVE_ASSERT_SVH
`define SOFT_KNEE_COMPRESSOR_CURVE_ASSERT_SVH
`ifndef SYNTH
`define SKCC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SKCC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SKCC_ASSERT_IMPL(lbl, ante, cons)
`define SKCC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### hdl/skcc_pkg.sv
// shared constants and types for the soft-knee compressor curve
`default_nettype none
package skcc_pkg;
    localparam int unsigned LVL_W   = 16;
    localparam int unsigned RATIO_W = 11;
    localparam int unsigned KNEE_W  = 4;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned NUM_W   = 41;
    localparam int unsigned DEN_W   = 27;
    localparam int unsigned QUOT_W  = 18;
    localparam logic [RATIO_W-1:0] RATIO_UNITY = 11'd16;
    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_RATIO     = 2'd1;
    localparam logic [1:0] CFG_KNEE      = 2'd2;
    localparam logic [LVL_W-1:0]   THRESHOLD_RST = 16'hEC00;
    localparam logic [RATIO_W-1:0] RATIO_RST     = 11'd64;
    localparam logic [KNEE_W-1:0]  KNEE_RST      = 4'd0;
    typedef logic [LVL_W-1:0] t_level;
endpackage
`default_nettype wire

### hdl/skcc_div.sv
// pipelined restoring divider, one quotient bit per stage, level carried along
`default_nettype none
module skcc_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [skcc_pkg::NUM_W-1:0]   i_num,
    input  wire logic [skcc_pkg::DEN_W-1:0]   i_den,
    input  wire skcc_pkg::t_level             i_level,
    output logic                              o_valid,
    output logic [skcc_pkg::QUOT_W-1:0]       o_quot,
    output skcc_pkg::t_level                  o_level
);
    localparam int unsigned QW = skcc_pkg::QUOT_W;
    localparam int unsigned SW = skcc_pkg::NUM_W + 4;

    logic                          r_v   [QW];
    logic [skcc_pkg::NUM_W-1:0]    r_rem [QW];
    logic [skcc_pkg::DEN_W-1:0]    r_den [QW];
    logic [QW-1:0]                 r_q   [QW];
    skcc_pkg::t_level              r_lvl [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        localparam int unsigned SH = QW - 1 - i;
        logic                          w_v;
        logic [skcc_pkg::NUM_W-1:0]    w_rem;
        logic [skcc_pkg::DEN_W-1:0]    w_den;
        logic [QW-1:0]                 w_q;
        skcc_pkg::t_level              w_lvl;
        logic [SW-1:0]                 w_trial;
        logic [SW-1:0]                 w_rem_ext;
        logic                          w_ge;
        if (i == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = i_num;
            assign w_den = i_den;
            assign w_q   = '0;
            assign w_lvl = i_level;
        end else begin : g_next
            assign w_v   = r_v[i-1];
            assign w_rem = r_rem[i-1];
            assign w_den = r_den[i-1];
            assign w_q   = r_q[i-1];
            assign w_lvl = r_lvl[i-1];
        end
        assign w_trial   = SW'(w_den) << SH;
        assign w_rem_ext = SW'(w_rem);
        assign w_ge      = (w_rem_ext >= w_trial);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[i] <= 1'b0;
            end else begin
                r_v[i] <= w_v;
            end
            r_den[i] <= w_den;
            r_lvl[i] <= w_lvl;
            r_rem[i] <= w_ge ? skcc_pkg::NUM_W'(w_rem_ext - w_trial) : w_rem;
            r_q[i]   <= w_q | (QW'(w_ge) << SH);
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_level = r_lvl[QW-1];

    `include "soft_knee_compressor_curve_assert.svh"
    // remainder ends below the divisor
    `SKCC_ASSERT_IMPL(a_rem_below_den, r_v[QW-1], r_rem[QW-1] < skcc_pkg::NUM_W'(r_den[QW-1]))
    // valid walks down the stages
    `SKCC_ASSERT_NEXT(a_valid_moves, i_valid, r_v[0])
    // last stage follows the one before
    `SKCC_ASSERT_NEXT(a_valid_out, r_v[QW-2], o_valid)
endmodule
`default_nettype wire

### hdl/soft_knee_compressor_curve.sv
// top level of the soft-knee compressor static curve
// usage:
//   write threshold (index 0), ratio (index 1) and knee (index 2) through
//   i_cfg_we / i_cfg_addr / i_cfg_data while no transfer is in flight
//   a level is taken at each rising edge with start high and busy low;
//   busy is always low, so one level can enter every cycle
//   each result appears on o_level_out_db for one cycle with o_strobe high,
//   in input order
//   throughput is one level per cycle; latency is set by the 18-stage
//   divider (one quotient bit per stage) plus four front stages
//   and the output register
//   reset clears every valid bit and loads the default curve
//   (-20 dB threshold, 4:1, hard knee)
//   the receiver cannot stall: results are never held
`default_nettype none
module soft_knee_compressor_curve (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [skcc_pkg::LVL_W-1:0] i_level_in_db,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_addr,
    input  wire logic [skcc_pkg::CFG_W-1:0]     i_cfg_data,
    output logic                                o_strobe,
    output logic signed [skcc_pkg::LVL_W-1:0]   o_level_out_db
);
    logic [15:0]                   r_thr;
    logic [skcc_pkg::RATIO_W-1:0]  r_ratio;
    logic [skcc_pkg::KNEE_W-1:0]   r_knee;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= skcc_pkg::THRESHOLD_RST;
            r_ratio <= skcc_pkg::RATIO_RST;
            r_knee  <= skcc_pkg::KNEE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                skcc_pkg::CFG_THRESHOLD: r_thr   <= i_cfg_data;
                skcc_pkg::CFG_RATIO:     r_ratio <= i_cfg_data[skcc_pkg::RATIO_W-1:0];
                skcc_pkg::CFG_KNEE:      r_knee  <= i_cfg_data[skcc_pkg::KNEE_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: excess over threshold
    logic                  r_s1_v;
    skcc_pkg::t_level      r_s1_lvl;
    logic signed [16:0]    r_s1_x;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= start && !busy;
        end
        r_s1_lvl <= i_level_in_db;
        r_s1_x   <= 17'(signed'({i_level_in_db[15], i_level_in_db}))
                  - 17'(signed'({r_thr[15], r_thr}));
    end

    // stage 2: region, knee square, divisor
    logic [13:0]                  w_half;
    logic signed [17:0]           w_t;
    logic                         w_zero;
    logic                         w_inside;
    logic [skcc_pkg::RATIO_W-1:0] w_reff;
    logic [14:0]                  w_rk;
    always_comb begin
        w_half = 14'(r_knee) * 14'd384;
        w_t    = 18'(r_s1_x) + 18'(signed'({1'b0, w_half}));
        w_reff = (r_ratio < skcc_pkg::RATIO_UNITY) ? skcc_pkg::RATIO_UNITY : r_ratio;
        w_rk   = 15'(w_reff) * 15'(r_knee);
        if (r_knee == '0) begin
            w_zero   = (r_s1_x <= 17'sd0);
            w_inside = 1'b0;
        end else begin
            w_zero   = (w_t <= 18'sd0);
            w_inside = !w_zero && (r_s1_x < 17'(signed'({1'b0, w_half})));
        end
    end

    logic                         r_s2_v;
    skcc_pkg::t_level             r_s2_lvl;
    logic [27:0]                  r_s2_a;
    logic [skcc_pkg::DEN_W-2:0]   r_s2_d;
    logic [skcc_pkg::RATIO_W-1:0] r_s2_sm;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_lvl <= r_s1_lvl;
        r_s2_sm  <= w_reff - skcc_pkg::RATIO_UNITY;
        if (w_zero) begin
            r_s2_a <= '0;
        end else if (w_inside) begin
            r_s2_a <= 28'(w_t[13:0]) * 28'(w_t[13:0]);
        end else begin
            r_s2_a <= 28'(r_s1_x[15:0]);
        end
        r_s2_d <= w_inside ? {w_rk, 11'd0} - {1'b0, w_rk, 10'd0} + {2'b0, w_rk, 9'd0}
                           : 26'(w_reff);
    end

    // stage 3: slope product
    logic                         r_s3_v;
    skcc_pkg::t_level             r_s3_lvl;
    logic [38:0]                  r_s3_m;
    logic [skcc_pkg::DEN_W-2:0]   r_s3_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
        r_s3_lvl <= r_s2_lvl;
        r_s3_m   <= 39'(r_s2_a) * 39'(r_s2_sm);
        r_s3_d   <= r_s2_d;
    end

    // stage 4: rounding numerator and doubled divisor
    logic                         r_s4_v;
    skcc_pkg::t_level             r_s4_lvl;
    logic [skcc_pkg::NUM_W-1:0]   r_s4_n;
    logic [skcc_pkg::DEN_W-1:0]   r_s4_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else begin
            r_s4_v <= r_s3_v;
        end
        r_s4_lvl <= r_s3_lvl;
        r_s4_n   <= {1'b0, r_s3_m, 1'b0} + skcc_pkg::NUM_W'(r_s3_d) - 41'd1;
        r_s4_d   <= {r_s3_d, 1'b0};
    end

    logic                        w_div_v;
    logic [skcc_pkg::QUOT_W-1:0] w_div_q;
    skcc_pkg::t_level            w_div_lvl;

    skcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s4_v),
        .i_num   (r_s4_n),
        .i_den   (r_s4_d),
        .i_level (r_s4_lvl),
        .o_valid (w_div_v),
        .o_quot  (w_div_q),
        .o_level (w_div_lvl)
    );

    // output: subtract reduction and saturate
    logic signed [18:0] w_res;
    logic               r_out_v;
    logic [15:0]        r_out;
    assign w_res = 19'(signed'({w_div_lvl[15], w_div_lvl}))
                 - 19'(signed'({1'b0, w_div_q}));
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= w_div_v;
        end
        r_out <= (w_res < -19'sd32768) ? 16'h8000 : w_res[15:0];
    end

    assign o_strobe       = r_out_v;
    assign o_level_out_db = r_out;

    `include "soft_knee_compressor_curve_assert.svh"
    // inside the knee only with a knee set
    `SKCC_ASSERT_IMPL(a_knee_region, w_inside, r_knee != '0)
    // every divider result gives a strobe
    `SKCC_ASSERT_NEXT(a_strobe_src, w_div_v, o_strobe)
    // output never above the input level
    `SKCC_ASSERT_IMPL(a_no_gain, w_div_v, w_res <= 19'(signed'({w_div_lvl[15], w_div_lvl})))
endmodule
`default_nettype wire
